[sv/msrm_pkg.sv]
// ----------------------------------------------------------------------------
// msrm_pkg
// Types, codes and constants shared by the status reply monitor modules.
// ----------------------------------------------------------------------------
package msrm_pkg;

	// default number of serial ports served
	localparam int DEFAULT_NUM_PORTS = 4;

	// crc-16 (modbus rtu, reflected)
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// frame layout
	localparam logic [7:0] HDR_ADDR   = 8'h01;
	localparam logic [7:0] HDR_FUNC   = 8'h03;
	localparam logic [7:0] GOOD_LEN   = 8'h14;
	localparam logic [8:0] STATUS_POS = 9'd4;
	localparam logic [8:0] HDR_BYTES  = 9'd3;

	// status byte flags
	localparam logic [7:0] STAT_ENC = 8'h10;
	localparam logic [7:0] STAT_POS = 8'h40;

	// report codes
	typedef enum logic [1:0] {
		EV_OK      = 2'd0,
		EV_ERR     = 2'd1,
		EV_TIMEOUT = 2'd2
	} event_t;

	// request kinds
	typedef enum logic {
		ACT_BYTE = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	// per-port receive phase
	typedef enum logic [2:0] {
		PH_HUNT1 = 3'd0,
		PH_HUNT2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_BODY  = 3'd3,
		PH_CRCLO = 3'd4,
		PH_CRCHI = 3'd5
	} phase_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DECODE = 2'd1,
		ST_CRC    = 2'd2,
		ST_TICK   = 2'd3
	} seq_state_t;

	// request payload
	typedef struct packed {
		action_t     action;
		logic [1:0]  port;
		logic [7:0]  data_byte;
	} req_t;

	// report payload
	typedef struct packed {
		logic [1:0]  out_port;
		event_t      event_res;
		logic        encoder_error;
		logic        position_error;
		logic        last;
	} rsp_t;

	// crc unit status
	typedef struct packed {
		logic        busy;
		logic        done;
	} crc_stat_t;

endpackage

[sv/modbus_status_reply_monitor_core.sv]
// ----------------------------------------------------------------------------
// modbus_status_reply_monitor_core
// Per-port modbus rtu reply receiver with crc check and timeout reporting.
// ----------------------------------------------------------------------------
// Usage: the request channel (req_valid/req_ready/req_data) carries either a
// received byte tagged with its port or a timeout tick. The report channel
// (rsp_valid/rsp_ready/rsp_data) returns driver ok / driver error reports for
// good 25-byte status frames and one timeout report per unanswered active
// port on a tick; the last report of a request has last set.
// Timing: one request at a time. A byte that updates the crc passes accept,
// decode, then eight shifts of the shared bit-serial crc unit before the next
// acceptance; a byte without crc work (crc bytes, unused port) returns from
// decode to idle. A tick walks the active ports, one port per cycle through
// the shared port walk, holding on a timeout while the report register is full.
// A report sits in a single output register; when the receiver stalls and
// the register is full, the sequencer holds until it drains.
// Reset clears all per-port state and sets the active port count to zero;
// writing cfg_wdata via cfg_we sets the count and clears all per-port state.
// ----------------------------------------------------------------------------
module modbus_status_reply_monitor_core #(
	parameter int NUM_PORTS = msrm_pkg::DEFAULT_NUM_PORTS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  msrm_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output msrm_pkg::rsp_t rsp_data,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_wdata
);

	localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int CNT_W = $clog2(NUM_PORTS + 1);
	localparam logic [CNT_W-1:0] NP_C = CNT_W'(NUM_PORTS);

	// sequencer and request register
	msrm_pkg::seq_state_t st_q, st_nxt;
	msrm_pkg::req_t       req_q;
	logic [2:0]           ports_q;
	logic [CNT_W-1:0]     idx_q;

	// per-port state
	msrm_pkg::phase_t phase_q [NUM_PORTS];
	logic [8:0]       count_q [NUM_PORTS];
	logic [7:0]       len_q   [NUM_PORTS];
	logic [15:0]      crc_q   [NUM_PORTS];
	logic [7:0]       stat_q  [NUM_PORTS];
	logic             match_q [NUM_PORTS];
	logic [NUM_PORTS-1:0] seen_q;

	// report register
	logic           rsp_valid_q;
	msrm_pkg::rsp_t rsp_q;

	// crc unit
	logic                crc_start;
	logic [15:0]         crc_seed;
	msrm_pkg::crc_stat_t crc_stat;
	logic [15:0]         crc_result;

	// decode results
	logic [CNT_W-1:0] n_act;
	logic [IDX_W-1:0] pidx;
	logic [IDX_W-1:0] tidx;
	logic             port_act;
	logic             is_tick;
	msrm_pkg::phase_t n_phase;
	logic [8:0]       n_count;
	logic [8:0]       cnt_inc;
	logic [7:0]       n_len;
	logic [7:0]       n_stat;
	logic             n_match;
	logic             crc_go;
	logic             crc_rst;
	logic             res_go;
	logic             slot_free;
	logic             commit;
	logic             tick_live;
	logic             tick_emit;
	logic             tick_adv;
	logic             tick_more;
	logic             rsp_load;
	msrm_pkg::rsp_t   frame_res;
	msrm_pkg::rsp_t   tick_res;

	// shared crc shifter
	msrm_crc_unit u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (crc_start),
		.seed      (crc_seed),
		.data_byte (req_q.data_byte),
		.stat      (crc_stat),
		.result    (crc_result)
	);

	// active port count, capped at the port capacity
	assign n_act    = (32'(ports_q) > NUM_PORTS) ? NP_C : CNT_W'(ports_q);
	assign pidx     = IDX_W'(req_q.port);
	assign tidx     = idx_q[IDX_W-1:0];
	assign port_act = 32'(req_q.port) < 32'(n_act);
	assign is_tick  = (req_q.action == msrm_pkg::ACT_TICK);
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign cnt_inc  = count_q[pidx] + 9'd1;

	// byte decode for the addressed port
	always_comb begin
		n_phase = phase_q[pidx];
		n_count = count_q[pidx];
		n_len   = len_q[pidx];
		n_stat  = stat_q[pidx];
		n_match = match_q[pidx];
		crc_go  = 1'b0;
		crc_rst = 1'b0;
		crc_seed = crc_q[pidx];
		res_go  = 1'b0;
		case (phase_q[pidx])
			msrm_pkg::PH_HUNT1: begin
				if (req_q.data_byte == msrm_pkg::HDR_ADDR) begin
					crc_go   = 1'b1;
					crc_seed = msrm_pkg::CRC_INIT;
					n_count  = 9'd1;
					n_phase  = msrm_pkg::PH_HUNT2;
				end
			end
			msrm_pkg::PH_HUNT2: begin
				if (req_q.data_byte == msrm_pkg::HDR_FUNC) begin
					crc_go  = 1'b1;
					n_count = 9'd2;
					n_phase = msrm_pkg::PH_LEN;
				end else if (req_q.data_byte == msrm_pkg::HDR_ADDR) begin
					crc_go   = 1'b1;
					crc_seed = msrm_pkg::CRC_INIT;
					n_count  = 9'd1;
				end else begin
					n_phase = msrm_pkg::PH_HUNT1;
					n_count = 9'd0;
					n_len   = 8'd0;
					n_stat  = 8'd0;
					n_match = 1'b0;
					crc_rst = 1'b1;
				end
			end
			msrm_pkg::PH_LEN: begin
				n_len   = req_q.data_byte;
				crc_go  = 1'b1;
				n_count = msrm_pkg::HDR_BYTES;
				n_phase = (req_q.data_byte == 8'd0) ? msrm_pkg::PH_CRCLO : msrm_pkg::PH_BODY;
			end
			msrm_pkg::PH_BODY: begin
				if (count_q[pidx] == msrm_pkg::STATUS_POS) begin
					n_stat = req_q.data_byte;
				end
				crc_go  = 1'b1;
				n_count = cnt_inc;
				if (cnt_inc >= (msrm_pkg::HDR_BYTES + {1'b0, len_q[pidx]})) begin
					n_phase = msrm_pkg::PH_CRCLO;
				end
			end
			msrm_pkg::PH_CRCLO: begin
				n_match = (req_q.data_byte == crc_q[pidx][7:0]);
				n_count = cnt_inc;
				n_phase = msrm_pkg::PH_CRCHI;
			end
			msrm_pkg::PH_CRCHI: begin
				res_go = match_q[pidx] && (req_q.data_byte == crc_q[pidx][15:8])
					&& (len_q[pidx] == msrm_pkg::GOOD_LEN);
				n_phase = msrm_pkg::PH_HUNT1;
				n_count = 9'd0;
				n_len   = 8'd0;
				n_stat  = 8'd0;
				n_match = 1'b0;
				crc_rst = 1'b1;
			end
			default: begin
				n_phase = msrm_pkg::PH_HUNT1;
				n_count = 9'd0;
				n_len   = 8'd0;
				n_stat  = 8'd0;
				n_match = 1'b0;
				crc_rst = 1'b1;
			end
		endcase
	end

	// frame report from the stored status byte
	always_comb begin
		frame_res.out_port       = req_q.port;
		frame_res.event_res      = ((stat_q[pidx] & (msrm_pkg::STAT_ENC | msrm_pkg::STAT_POS))
			== 8'd0) ? msrm_pkg::EV_OK : msrm_pkg::EV_ERR;
		frame_res.encoder_error  = |(stat_q[pidx] & msrm_pkg::STAT_ENC);
		frame_res.position_error = |(stat_q[pidx] & msrm_pkg::STAT_POS);
		frame_res.last           = 1'b1;
	end

	// any unanswered active port beyond the current walk position
	always_comb begin
		tick_more = 1'b0;
		for (int j = 0; j < NUM_PORTS; j++) begin
			if ((j > int'(idx_q)) && (j < int'(n_act)) && !seen_q[j]) begin
				tick_more = 1'b1;
			end
		end
	end

	// timeout report for the current walk position
	always_comb begin
		tick_res.out_port       = 2'(idx_q);
		tick_res.event_res      = msrm_pkg::EV_TIMEOUT;
		tick_res.encoder_error  = 1'b0;
		tick_res.position_error = 1'b0;
		tick_res.last           = !tick_more;
	end

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			msrm_pkg::ST_IDLE: begin
				if (req_valid) begin
					st_nxt = msrm_pkg::ST_DECODE;
				end
			end
			msrm_pkg::ST_DECODE: begin
				if (is_tick) begin
					st_nxt = msrm_pkg::ST_TICK;
				end else if (!port_act) begin
					st_nxt = msrm_pkg::ST_IDLE;
				end else if (res_go && !slot_free) begin
					st_nxt = msrm_pkg::ST_DECODE;
				end else if (crc_go) begin
					st_nxt = msrm_pkg::ST_CRC;
				end else begin
					st_nxt = msrm_pkg::ST_IDLE;
				end
			end
			msrm_pkg::ST_CRC: begin
				if (crc_stat.done) begin
					st_nxt = msrm_pkg::ST_IDLE;
				end
			end
			msrm_pkg::ST_TICK: begin
				if (idx_q >= n_act) begin
					st_nxt = msrm_pkg::ST_IDLE;
				end
			end
			default: st_nxt = msrm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready = (st_q == msrm_pkg::ST_IDLE);
		commit    = (st_q == msrm_pkg::ST_DECODE) && !is_tick && port_act
			&& !(res_go && !slot_free);
		crc_start = commit && crc_go;
		tick_live = (st_q == msrm_pkg::ST_TICK) && (idx_q < n_act);
		tick_emit = tick_live && !seen_q[tidx];
		tick_adv  = tick_live && (seen_q[tidx] || slot_free);
		rsp_load  = (commit && res_go) || (tick_emit && slot_free);
	end

	// sequencer state, walk counter and port count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= msrm_pkg::ST_IDLE;
			idx_q   <= '0;
			ports_q <= 3'd0;
		end else begin
			st_q <= st_nxt;
			if (cfg_we) begin
				ports_q <= cfg_wdata;
			end
			if (st_q == msrm_pkg::ST_DECODE) begin
				idx_q <= '0;
			end else if (tick_adv) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	// request register
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req_data;
		end
	end

	// per-port state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				phase_q[i] <= msrm_pkg::PH_HUNT1;
				count_q[i] <= 9'd0;
				len_q[i]   <= 8'd0;
				crc_q[i]   <= msrm_pkg::CRC_INIT;
				stat_q[i]  <= 8'd0;
				match_q[i] <= 1'b0;
			end
			seen_q <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				phase_q[i] <= msrm_pkg::PH_HUNT1;
				count_q[i] <= 9'd0;
				len_q[i]   <= 8'd0;
				crc_q[i]   <= msrm_pkg::CRC_INIT;
				stat_q[i]  <= 8'd0;
				match_q[i] <= 1'b0;
			end
			seen_q <= '0;
		end else begin
			if (commit) begin
				phase_q[pidx] <= n_phase;
				count_q[pidx] <= n_count;
				len_q[pidx]   <= n_len;
				stat_q[pidx]  <= n_stat;
				match_q[pidx] <= n_match;
				if (crc_rst) begin
					crc_q[pidx] <= msrm_pkg::CRC_INIT;
				end
				if (res_go) begin
					seen_q[pidx] <= 1'b1;
				end
			end
			if ((st_q == msrm_pkg::ST_CRC) && crc_stat.done) begin
				crc_q[pidx] <= crc_result;
			end
			if (tick_adv) begin
				seen_q[tidx] <= 1'b0;
			end
		end
	end

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= (st_q == msrm_pkg::ST_TICK) ? tick_res : frame_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

[sv/msrm_crc_unit.sv]
// ----------------------------------------------------------------------------
// msrm_crc_unit
// Bit-serial crc-16 shifter: folds one byte into a crc, one bit per cycle.
// ----------------------------------------------------------------------------
module msrm_crc_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         seed,
	input  logic [7:0]          data_byte,
	output msrm_pkg::crc_stat_t stat,
	output logic [15:0]         result
);

	logic [15:0] crc_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic [15:0] crc_step;

	// one shift of the reflected polynomial
	assign crc_step = crc_q[0] ? ((crc_q >> 1) ^ msrm_pkg::CRC_POLY) : (crc_q >> 1);

	// status and final value, valid in the cycle of the eighth shift
	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == 3'd7);
	assign result    = crc_step;

	// control: bit counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 3'd0;
			busy_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 3'd0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift register
	always_ff @(posedge clk) begin
		if (start) begin
			crc_q <= seed ^ {8'h00, data_byte};
		end else if (busy_q) begin
			crc_q <= crc_step;
		end
	end

endmodule

[tb/modbus_status_reply_monitor_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_status_reply_monitor_core_tb
// Drives port-tagged bytes and timeout ticks into the status reply monitor.
// A scoreboard class predicts the per-port frame hunting, the crc-16 check
// and the timeout walk. Every report is checked field by field against the
// oldest predicted one. The active port count is changed between phases while
// the block is idle. Both handshakes idle at random, and the report side is
// held off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module modbus_status_reply_monitor_core_tb;

	localparam int NPORTS        = msrm_pkg::DEFAULT_NUM_PORTS;
	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 24;
	localparam int ITEMS         = 370;
	localparam int HOLD_CYCLES   = 300;
	localparam int LIMIT_NS      = 6000000;

	// per-port receive prediction and the queue of reports still due
	class reply_tracker;
		int unsigned      active;
		msrm_pkg::phase_t rx_phase [NPORTS];
		logic [8:0]       byte_cnt [NPORTS];
		logic [7:0]       frame_len [NPORTS];
		logic [15:0]      crc_acc [NPORTS];
		logic [7:0]       status [NPORTS];
		bit               crc_lo_ok [NPORTS];
		bit               answered [NPORTS];
		msrm_pkg::rsp_t   due_reports [$];
		int               errors;

		function new();
			errors = 0;
			set_ports(3'd0);
		endfunction

		// one byte through the reflected crc-16
		function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
			logic [15:0] c;
			c = acc ^ {8'h00, b};
			for (int k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ msrm_pkg::CRC_POLY) : (c >> 1);
			return c;
		endfunction

		function void restart(int unsigned p);
			rx_phase[p]  = msrm_pkg::PH_HUNT1;
			byte_cnt[p]  = '0;
			frame_len[p] = '0;
			crc_acc[p]   = msrm_pkg::CRC_INIT;
			status[p]    = '0;
			crc_lo_ok[p] = 1'b0;
		endfunction

		// register write: new active count, all ports back to reset
		function void set_ports(logic [2:0] v);
			active = (v > NPORTS) ? NPORTS : v;
			for (int i = 0; i < NPORTS; i++) begin
				restart(i);
				answered[i] = 1'b0;
			end
		endfunction

		function void push_report(int unsigned p, msrm_pkg::event_t ev, bit enc, bit pos,
				bit fin);
			msrm_pkg::rsp_t r;
			r.out_port       = 2'(p);
			r.event_res      = ev;
			r.encoder_error  = enc;
			r.position_error = pos;
			r.last           = fin;
			due_reports.push_back(r);
		endfunction

		function void note_request(msrm_pkg::req_t q);
			int unsigned p;
			int          total;
			int          k;
			logic [7:0]  b;
			b = q.data_byte;
			p = q.port;
			// tick: one timeout per unanswered active port, then clear marks
			if (q.action == msrm_pkg::ACT_TICK) begin
				total = 0;
				for (int i = 0; i < active; i++)
					if (!answered[i])
						total++;
				k = 0;
				for (int i = 0; i < active; i++) begin
					if (!answered[i]) begin
						k++;
						push_report(i, msrm_pkg::EV_TIMEOUT, 1'b0, 1'b0, k == total);
					end
					answered[i] = 1'b0;
				end
				return;
			end
			if (p >= active)
				return;
			// byte: advance this port's frame receiver
			case (rx_phase[p])
				msrm_pkg::PH_HUNT1: begin
					if (b == msrm_pkg::HDR_ADDR) begin
						crc_acc[p]  = crc_step(msrm_pkg::CRC_INIT, b);
						byte_cnt[p] = 9'd1;
						rx_phase[p] = msrm_pkg::PH_HUNT2;
					end
				end
				msrm_pkg::PH_HUNT2: begin
					if (b == msrm_pkg::HDR_FUNC) begin
						crc_acc[p]  = crc_step(crc_acc[p], b);
						byte_cnt[p] = 9'd2;
						rx_phase[p] = msrm_pkg::PH_LEN;
					end else if (b == msrm_pkg::HDR_ADDR) begin
						crc_acc[p]  = crc_step(msrm_pkg::CRC_INIT, b);
						byte_cnt[p] = 9'd1;
					end else begin
						restart(p);
					end
				end
				msrm_pkg::PH_LEN: begin
					frame_len[p] = b;
					crc_acc[p]   = crc_step(crc_acc[p], b);
					byte_cnt[p]  = msrm_pkg::HDR_BYTES;
					rx_phase[p]  = (b == 8'h00) ? msrm_pkg::PH_CRCLO : msrm_pkg::PH_BODY;
				end
				msrm_pkg::PH_BODY: begin
					if (byte_cnt[p] == msrm_pkg::STATUS_POS)
						status[p] = b;
					crc_acc[p]  = crc_step(crc_acc[p], b);
					byte_cnt[p] = byte_cnt[p] + 9'd1;
					if (byte_cnt[p] >= msrm_pkg::HDR_BYTES + {1'b0, frame_len[p]})
						rx_phase[p] = msrm_pkg::PH_CRCLO;
				end
				msrm_pkg::PH_CRCLO: begin
					crc_lo_ok[p] = (b == crc_acc[p][7:0]);
					byte_cnt[p]  = byte_cnt[p] + 9'd1;
					rx_phase[p]  = msrm_pkg::PH_CRCHI;
				end
				msrm_pkg::PH_CRCHI: begin
					if (crc_lo_ok[p] && b == crc_acc[p][15:8]
							&& frame_len[p] == msrm_pkg::GOOD_LEN) begin
						answered[p] = 1'b1;
						if ((status[p] & (msrm_pkg::STAT_ENC | msrm_pkg::STAT_POS)) == 8'h00)
							push_report(p, msrm_pkg::EV_OK, 1'b0, 1'b0, 1'b1);
						else
							push_report(p, msrm_pkg::EV_ERR, |(status[p] & msrm_pkg::STAT_ENC),
								|(status[p] & msrm_pkg::STAT_POS), 1'b1);
					end
					restart(p);
				end
				default: restart(p);
			endcase
		endfunction

		function void field_check(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_report(msrm_pkg::rsp_t got);
			msrm_pkg::rsp_t want;
			if (due_reports.size() == 0) begin
				$display("%0t: unexpected report, expected none, got port %0d event %0d",
					$time, got.out_port, got.event_res);
				errors++;
				return;
			end
			want = due_reports.pop_front();
			field_check("out_port", want.out_port, got.out_port);
			field_check("event_res", want.event_res, got.event_res);
			field_check("encoder_error", want.encoder_error, got.encoder_error);
			field_check("position_error", want.position_error, got.position_error);
			field_check("last", want.last, got.last);
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	msrm_pkg::req_t req_data;
	logic           rsp_valid;
	logic           rsp_ready;
	msrm_pkg::rsp_t rsp_data;
	logic           cfg_we;
	logic [2:0]     cfg_wdata;

	reply_tracker model = new();
	bit           tx_eager;
	bit           rx_eager;
	int           long_hold;
	int           sent_items;

	modbus_status_reply_monitor_core #(
		.NUM_PORTS(NPORTS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// run limit
	initial begin
		#(LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

	// offer one request after a random gap, note it once accepted
	task automatic offer(input msrm_pkg::req_t q);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= q;
		do @(posedge clk); while (!req_ready);
		model.note_request(q);
		sent_items++;
	endtask

	task automatic send_byte(input logic [1:0] p, input logic [7:0] b);
		msrm_pkg::req_t q;
		q.action    = msrm_pkg::ACT_BYTE;
		q.port      = p;
		q.data_byte = b;
		offer(q);
	endtask

	// tick with random filler in the unused fields
	task automatic send_tick();
		msrm_pkg::req_t q;
		q.action    = msrm_pkg::ACT_TICK;
		q.port      = 2'($urandom);
		q.data_byte = 8'($urandom);
		offer(q);
	endtask

	// whole frame on one port, now and then another request slipped in
	task automatic send_frame(input logic [1:0] p, input logic [7:0] flen,
			input logic [7:0] stat, input bit spoil);
		logic [7:0]  frame [$];
		logic [15:0] crc;
		int          i;
		frame = {msrm_pkg::HDR_ADDR, msrm_pkg::HDR_FUNC, flen};
		for (i = 0; i < flen; i++)
			frame.push_back((i == 1) ? stat : 8'($urandom));
		crc = msrm_pkg::CRC_INIT;
		for (i = 0; i < frame.size(); i++)
			crc = model.crc_step(crc, frame[i]);
		frame.push_back(crc[7:0]);
		frame.push_back(crc[15:8]);
		if (spoil) begin
			i = $urandom_range(2, frame.size() - 1);
			frame[i] = frame[i] ^ (8'h01 << $urandom_range(0, 7));
		end
		for (i = 0; i < frame.size(); i++) begin
			if ($urandom_range(0, 99) < 6) begin
				if ($urandom_range(0, 3) == 0)
					send_tick();
				else
					send_byte(2'(p + 2'($urandom_range(1, 3))), 8'($urandom));
			end
			send_byte(p, frame[i]);
		end
	endtask

	// drop valid and wait until every predicted report is back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (model.due_reports.size() != 0) @(posedge clk);
	endtask

	// active port count, written only while idle
	task automatic write_ports(input logic [2:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		model.set_ports(v);
		cfg_we <= 1'b0;
	endtask

	// report side: random stalls, one long hold when asked
	initial begin
		int stall;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold != 0) begin
				stall     = long_hold;
				long_hold = 0;
			end else begin
				stall = rx_eager ? 0 : $urandom_range(0, 4);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			model.check_report(rsp_data);
		end
	end

	// request side: reset, directed cases, random phases, drain
	initial begin
		logic [2:0]  cfg_plan [8];
		logic [1:0]  port;
		int unsigned n;
		int          quota;
		int          pick;
		int          ph;

		cfg_plan   = '{3'd1, 3'd4, 3'd0, 3'd3, 3'd7, 3'd2, 3'd5, 3'd4};
		sent_items = 0;
		long_hold  = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_data  <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// good frame with both flags, then ticks with and without answers
		write_ports(3'd4);
		send_frame(2'd3, msrm_pkg::GOOD_LEN, msrm_pkg::STAT_ENC | msrm_pkg::STAT_POS, 1'b0);
		send_tick();
		send_tick();
		// repeated first header byte leading into a zero length frame
		send_byte(2'd1, msrm_pkg::HDR_ADDR);
		send_byte(2'd1, msrm_pkg::HDR_ADDR);
		send_frame(2'd1, 8'h00, 8'h00, 1'b0);
		send_byte(2'd0, 8'h00);
		send_byte(2'd0, 8'hFF);
		// bytes on ports not in use are dropped
		write_ports(3'd2);
		send_byte(2'd3, 8'hFF);
		send_byte(2'd2, msrm_pkg::HDR_ADDR);
		send_tick();
		// count above the port total acts as the total
		write_ports(3'd7);
		send_tick();

		for (ph = 0; ph < 8; ph++) begin
			write_ports(cfg_plan[ph]);
			n        = (cfg_plan[ph] > NPORTS) ? NPORTS : cfg_plan[ph];
			tx_eager = ($urandom_range(0, 2) == 0);
			rx_eager = ($urandom_range(0, 2) == 0);
			quota    = sent_items + ((n == 0) ? 8 : 24);

			// back up the report path, then pause until it drains
			if (ph == 1) begin
				long_hold = HOLD_CYCLES;
				repeat (6) send_tick();
				send_frame(2'd0, msrm_pkg::GOOD_LEN, msrm_pkg::STAT_ENC, 1'b0);
				wait_drained();
			end

			while (sent_items < quota || (ph == 7 && sent_items < ITEMS)) begin
				pick = $urandom_range(0, 99);
				if (n == 0)
					port = 2'($urandom);
				else if ($urandom_range(0, 9) == 0)
					port = 2'($urandom);
				else
					port = 2'($urandom_range(0, n - 1));

				if (pick < 55) begin
					send_frame(port, msrm_pkg::GOOD_LEN, 8'($urandom), 1'b0);
				end else if (pick < 65) begin
					// broken frames: zero length, other length, bad crc, off by one
					case ($urandom_range(0, 3))
						0: send_frame(port, 8'h00, 8'h00, 1'b0);
						1: send_frame(port, 8'($urandom_range(1, 30)), 8'($urandom), 1'b0);
						2: send_frame(port, msrm_pkg::GOOD_LEN, 8'($urandom), 1'b1);
						default: send_frame(port, msrm_pkg::GOOD_LEN + 8'd1, 8'($urandom),
							1'b0);
					endcase
				end else if (pick < 78) begin
					send_tick();
				end else begin
					// noise leaning toward header bytes
					repeat ($urandom_range(1, 6)) begin
						case ($urandom_range(0, 3))
							0: send_byte(2'($urandom), msrm_pkg::HDR_ADDR);
							1: send_byte(2'($urandom), msrm_pkg::HDR_FUNC);
							default: send_byte(2'($urandom), 8'($urandom));
						endcase
					end
				end
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (model.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
sv/msrm_pkg.sv
sv/msrm_crc_unit.sv
sv/modbus_status_reply_monitor_core.sv
tb/modbus_status_reply_monitor_core_tb.sv
